>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent checks used by the top-level RTL file, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> src/ppa_pkg.sv
// ----------------------------------------------------------------------------
// ppa_pkg
// Widths, payload types, sequencer states and control groups for the
// polygon perimeter and area block.
// ----------------------------------------------------------------------------
package ppa_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int COORD_BITS   = 16;
    localparam int FRAC_BITS    = 8;

    // Edge deltas carry one extra bit, squares and cross terms twice that
    localparam int DIFF_W  = COORD_BITS + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int RAD_W   = PROD_W + 2 * FRAC_BITS;
    localparam int ROOT_W  = RAD_W / 2;
    localparam int ITER_W  = $clog2(ROOT_W);

    localparam int LEN_W   = 35;
    localparam int AREA_W  = 42;
    localparam int CROSS_W = AREA_W + 1;
    localparam int COUNT_W = 11;
    localparam int CNT_W   = $clog2(MAX_VERTICES + 1);

    typedef struct packed {
        logic signed [COORD_BITS-1:0] vertex_x;
        logic signed [COORD_BITS-1:0] vertex_y;
        logic                         last_vertex;
    } ppa_in_t;

    typedef struct packed {
        logic [LEN_W-1:0]   perimeter_q8;
        logic [AREA_W-1:0]  area_doubled;
        logic [COUNT_W-1:0] vertex_count;
        logic               overflow;
    } ppa_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ENTER,
        ST_CHECK_LAST,
        ST_MUL_DX,
        ST_MUL_DY,
        ST_MUL_AB,
        ST_MUL_BA,
        ST_DIFF,
        ST_CSUM,
        ST_ROOT,
        ST_EMIT
    } ppa_state_t;

    // Operand pair on the shared multiplier
    typedef enum logic [1:0] {
        MS_DX,
        MS_DY,
        MS_AB,
        MS_BA
    } ppa_mul_sel_t;

    typedef struct packed {
        logic         s_ready;
        ppa_mul_sel_t mul_sel;
        logic         close_edge;
        logic         take_first;
        logic         set_ovf;
        logic         rad_load;
        logic         root_start;
        logic         cross_load;
        logic         cross_diff;
        logic         cross_acc;
        logic         len_acc;
        logic         adv_prev;
        logic         emit;
    } ppa_ctl_t;

    typedef struct packed {
        logic in_fire;
        logic item_last;
        logic closed;
        logic seen_zero;
        logic seen_full;
        logic root_busy;
        logic out_free;
    } ppa_sts_t;

endpackage

>>> src/ppa_mul.sv
// ----------------------------------------------------------------------------
// ppa_mul
// Shared signed multiplier with a registered product; serves the squared
// deltas and both cross terms in turn.
// ----------------------------------------------------------------------------
module ppa_mul
    import ppa_pkg::*;
(
    input  logic                     aclk,
    input  logic signed [DIFF_W-1:0] op_a,
    input  logic signed [DIFF_W-1:0] op_b,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [PROD_W-1:0] prod_reg;

    // Register the product for the next step
    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

>>> src/ppa_sqrt.sv
// ----------------------------------------------------------------------------
// ppa_sqrt
// Restoring integer square root, one result bit per cycle, two radicand
// bits consumed per step.
// ----------------------------------------------------------------------------
module ppa_sqrt
    import ppa_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [RAD_W-1:0]  radicand,
    output logic              busy,
    output logic [ROOT_W-1:0] root
);

    localparam int REM_W = ROOT_W + 2;

    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [ITER_W-1:0] iter_reg;
    logic              busy_reg;

    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+1:0]  trial;
    logic              fits;

    // Bring down the next pair and try the odd trial value
    always_comb begin
        rem_sh = {rem_reg, rad_reg[RAD_W-1 -: 2]};
        trial  = (REM_W + 2)'({root_reg, 2'b01});
        fits   = rem_sh >= trial;
    end

    // Control: busy after a start until all ROOT_W root bits are formed
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            iter_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            iter_reg <= '0;
        end else if (busy_reg) begin
            iter_reg <= iter_reg + 1'b1;
            if (iter_reg == ITER_W'(ROOT_W - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Datapath: shift radicand, update remainder and root
    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rad_reg <= rad_reg << 2;
            if (fits) begin
                rem_reg  <= REM_W'(rem_sh - trial);
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end else begin
                rem_reg  <= REM_W'(rem_sh);
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

>>> src/ppa_ctrl.sv
// ----------------------------------------------------------------------------
// ppa_ctrl
// Sequencer: steps each vertex through squares, root, cross terms and
// accumulation, then, in closed mode, the closing edge, and the result transfer.
// ----------------------------------------------------------------------------
module ppa_ctrl
    import ppa_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  ppa_sts_t sts,
    output ppa_ctl_t ctl
);

    ppa_state_t state_reg, state_next;
    logic       closing_reg, closing_next;

    // Hold state and closing-edge flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            closing_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            closing_reg <= closing_next;
        end
    end

    // Next state
    always_comb begin
        state_next   = state_reg;
        closing_next = closing_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (sts.in_fire) begin
                    state_next = ST_ENTER;
                end
            end
            ST_ENTER: begin
                if (sts.seen_full || sts.seen_zero) begin
                    state_next = ST_CHECK_LAST;
                end else begin
                    state_next = ST_MUL_DX;
                end
            end
            ST_CHECK_LAST: begin
                if (!sts.item_last) begin
                    state_next = ST_IDLE;
                end else if (sts.closed) begin
                    closing_next = 1'b1;
                    state_next   = ST_MUL_DX;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_MUL_DX: state_next = ST_MUL_DY;
            ST_MUL_DY: state_next = ST_MUL_AB;
            ST_MUL_AB: state_next = ST_MUL_BA;
            ST_MUL_BA: state_next = ST_DIFF;
            ST_DIFF:   state_next = ST_CSUM;
            ST_CSUM:   state_next = ST_ROOT;
            ST_ROOT: begin
                if (!sts.root_busy) begin
                    state_next = closing_reg ? ST_EMIT : ST_CHECK_LAST;
                end
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    closing_next = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        ctl            = '0;
        ctl.mul_sel    = MS_DX;
        ctl.close_edge = closing_reg;
        unique case (state_reg)
            ST_IDLE: ctl.s_ready = 1'b1;
            ST_ENTER: begin
                if (sts.seen_full) begin
                    ctl.set_ovf = 1'b1;
                end else if (sts.seen_zero) begin
                    ctl.take_first = 1'b1;
                end
            end
            ST_CHECK_LAST: ;
            ST_MUL_DX: ctl.mul_sel = MS_DX;
            ST_MUL_DY: begin
                ctl.mul_sel  = MS_DY;
                ctl.rad_load = 1'b1;
            end
            ST_MUL_AB: begin
                ctl.mul_sel    = MS_AB;
                ctl.root_start = 1'b1;
            end
            ST_MUL_BA: begin
                ctl.mul_sel    = MS_BA;
                ctl.cross_load = 1'b1;
            end
            ST_DIFF: ctl.cross_diff = 1'b1;
            ST_CSUM: ctl.cross_acc = 1'b1;
            ST_ROOT: begin
                ctl.len_acc  = !sts.root_busy;
                ctl.adv_prev = !sts.root_busy && !closing_reg;
            end
            ST_EMIT: ctl.emit = sts.out_free;
            default: ;
        endcase
    end

endmodule

>>> src/polygon_perimeter_and_area_top.sv
// The first vertex of a polygon is only stored; each further vertex waits on the
// 25-step square root shared by every edge.
// A last vertex in closed mode also runs the closing edge back to the first vertex;
// the result is valid from the cycle the input is ready again.
// A new vertex is taken only once the last one is through; a stalled result holds the input off.
// Reset (aresetn, synchronous, active low) clears sums and counts, sets closed mode.
// ----------------------------------------------------------------------------
// polygon_perimeter_and_area_top
// Polygon perimeter in Q8 and doubled shoelace area from a vertex stream,
// using one shared multiplier and one iterative square-root unit.
// ----------------------------------------------------------------------------
module polygon_perimeter_and_area_top
    import ppa_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  ppa_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output ppa_out_t m_data,
    input  logic     cfg_valid,
    output logic     cfg_ready,
    input  logic     cfg_data
);

`include "assert_macros.svh"

    ppa_ctl_t ctl;
    ppa_sts_t sts;

    logic                          closed_reg;
    ppa_in_t                       item_reg;
    logic signed [COORD_BITS-1:0]  first_x_reg, first_y_reg;
    logic signed [COORD_BITS-1:0]  prev_x_reg, prev_y_reg;
    logic [CNT_W-1:0]              seen_cnt_reg;
    logic                          ovf_reg;
    logic [LEN_W-1:0]              len_sum_reg;
    logic signed [CROSS_W-1:0]     cross_sum_reg;
    logic signed [PROD_W-1:0]      cross_reg;
    logic [PROD_W-1:0]             rad_reg;
    logic                          m_valid_reg;
    ppa_out_t                      m_data_reg;

    logic signed [COORD_BITS-1:0]  bx, by;
    logic signed [DIFF_W-1:0]      ax_e, ay_e, bx_e, by_e, dx, dy;
    logic signed [DIFF_W-1:0]      op_a, op_b;
    logic signed [PROD_W-1:0]      prod;
    logic [RAD_W-1:0]              radicand;
    logic                          root_busy;
    logic [ROOT_W-1:0]             root;
    logic [LEN_W:0]                len_sum_w;
    logic [LEN_W-1:0]              len_sat;
    logic signed [CROSS_W:0]       cross_sum_w;
    logic signed [CROSS_W-1:0]     cross_sat;
    logic [CROSS_W-1:0]            area_mag;
    logic [AREA_W-1:0]             area_sat;
    logic                          in_fire;

    // Configuration register: always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            closed_reg <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            closed_reg <= cfg_data;
        end
    end

    // Sequencer and status
    assign s_ready = ctl.s_ready;
    assign in_fire = s_valid && s_ready;

    assign sts.in_fire   = in_fire;
    assign sts.item_last = item_reg.last_vertex;
    assign sts.closed    = closed_reg;
    assign sts.seen_zero = seen_cnt_reg == '0;
    assign sts.seen_full = seen_cnt_reg == CNT_W'(MAX_VERTICES);
    assign sts.root_busy = root_busy;
    assign sts.out_free  = !m_valid_reg || m_ready;

    ppa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .sts     (sts),
        .ctl     (ctl)
    );

    // Edge operands: from previous vertex to new vertex or back to the first
    assign bx   = ctl.close_edge ? first_x_reg : item_reg.vertex_x;
    assign by   = ctl.close_edge ? first_y_reg : item_reg.vertex_y;
    assign ax_e = {prev_x_reg[COORD_BITS-1], prev_x_reg};
    assign ay_e = {prev_y_reg[COORD_BITS-1], prev_y_reg};
    assign bx_e = {bx[COORD_BITS-1], bx};
    assign by_e = {by[COORD_BITS-1], by};
    assign dx   = bx_e - ax_e;
    assign dy   = by_e - ay_e;

    // Select the multiplier operand pair
    always_comb begin
        unique case (ctl.mul_sel)
            MS_DX: begin
                op_a = dx;
                op_b = dx;
            end
            MS_DY: begin
                op_a = dy;
                op_b = dy;
            end
            MS_AB: begin
                op_a = ax_e;
                op_b = by_e;
            end
            MS_BA: begin
                op_a = ay_e;
                op_b = bx_e;
            end
            default: begin
                op_a = dx;
                op_b = dx;
            end
        endcase
    end

    ppa_mul u_mul (
        .aclk (aclk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    // Radicand: dx^2 + dy^2 scaled to the fraction width
    assign radicand = RAD_W'(rad_reg + $unsigned(prod)) << (2 * FRAC_BITS);

    ppa_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (ctl.root_start),
        .radicand (radicand),
        .busy     (root_busy),
        .root     (root)
    );

    // Saturating accumulators
    always_comb begin
        len_sum_w = {1'b0, len_sum_reg} + (LEN_W + 1)'(root);
        len_sat   = len_sum_w[LEN_W] ? {LEN_W{1'b1}} : len_sum_w[LEN_W-1:0];

        cross_sum_w = {cross_sum_reg[CROSS_W-1], cross_sum_reg}
                    + (CROSS_W + 1)'(cross_reg);
        if (cross_sum_w[CROSS_W] != cross_sum_w[CROSS_W-1]) begin
            cross_sat = cross_sum_w[CROSS_W] ? {1'b1, {(CROSS_W-1){1'b0}}}
                                             : {1'b0, {(CROSS_W-1){1'b1}}};
        end else begin
            cross_sat = cross_sum_w[CROSS_W-1:0];
        end

        area_mag = cross_sum_reg[CROSS_W-1] ? CROSS_W'(-cross_sum_reg)
                                            : CROSS_W'(cross_sum_reg);
        area_sat = area_mag[CROSS_W-1] ? {AREA_W{1'b1}} : area_mag[AREA_W-1:0];
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            item_reg <= s_data;
        end
        if (ctl.take_first) begin
            first_x_reg <= item_reg.vertex_x;
            first_y_reg <= item_reg.vertex_y;
        end
        if (ctl.take_first || ctl.adv_prev) begin
            prev_x_reg <= item_reg.vertex_x;
            prev_y_reg <= item_reg.vertex_y;
        end
        if (ctl.rad_load) begin
            rad_reg <= $unsigned(prod);
        end
        if (ctl.cross_load) begin
            cross_reg <= prod;
        end else if (ctl.cross_diff) begin
            cross_reg <= cross_reg - prod;
        end
    end

    // Per-polygon sums and count; drop them once the result is registered
    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.emit) begin
            seen_cnt_reg  <= '0;
            ovf_reg       <= 1'b0;
            len_sum_reg   <= '0;
            cross_sum_reg <= '0;
        end else begin
            if (ctl.take_first) begin
                seen_cnt_reg <= CNT_W'(1);
            end else if (ctl.adv_prev) begin
                seen_cnt_reg <= seen_cnt_reg + 1'b1;
            end
            if (ctl.set_ovf) begin
                ovf_reg <= 1'b1;
            end
            if (ctl.len_acc) begin
                len_sum_reg <= len_sat;
            end
            if (ctl.cross_acc) begin
                cross_sum_reg <= cross_sat;
            end
        end
    end

    // Result register: hold until the transfer completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctl.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.emit) begin
            m_data_reg.perimeter_q8 <= len_sum_reg;
            m_data_reg.area_doubled <= closed_reg ? area_sat : '0;
            m_data_reg.vertex_count <= COUNT_W'(seen_cnt_reg);
            m_data_reg.overflow     <= ovf_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Checks
    `ASSERT_IMPL(a_emit_free, aclk, aresetn, ctl.emit, !m_valid_reg || m_ready)
    `ASSERT_IMPL(a_root_idle, aclk, aresetn, ctl.root_start, !root_busy)
    `ASSERT_IMPL(a_cnt_bound, aclk, aresetn, 1'b1, seen_cnt_reg <= CNT_W'(MAX_VERTICES))
    `ASSERT_IMPL(a_ovf_full, aclk, aresetn, ovf_reg, sts.seen_full)
    `ASSERT_NEXT(a_one_item, aclk, aresetn, in_fire, !s_ready)

endmodule
